### sv/ple_pkg.sv
package ple_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned IdxW = 8;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_DUMP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [IdxW-1:0]       pos;
    logic [IdxW-1:0]       tail;
    logic [DataW-1:0]      value;
  } cell_ctl_t;

endpackage

### sv/ple_cell.sv
module ple_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk_i,
  input  ple_pkg::cell_ctl_t            ctl_i,
  input  logic                          in_list_i,
  input  logic [ple_pkg::DataW-1:0]     left_i,
  input  logic [ple_pkg::DataW-1:0]     right_i,
  input  logic [ple_pkg::DataW-1:0]     head_i,
  output logic [ple_pkg::DataW-1:0]     value_o,
  output logic                          match_o
);

  localparam logic [ple_pkg::IdxW-1:0] Idx = ple_pkg::IdxW'(IDX);

  logic [ple_pkg::DataW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    unique case (ctl_i.op)
      ple_pkg::OP_INSERT: begin
        if (Idx > ctl_i.pos) begin
          value_d = left_i;
        end else if (Idx == ctl_i.pos) begin
          value_d = ctl_i.value;
        end
      end
      ple_pkg::OP_ERASE: begin
        if (Idx >= ctl_i.pos) begin
          value_d = right_i;
        end
      end
      ple_pkg::OP_ROTATE: begin
        if (Idx == ctl_i.tail) begin
          value_d = head_i;
        end else if (Idx < ctl_i.tail) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = in_list_i && (value_q == ctl_i.value);

endmodule

### sv/positional_list_engine_unit.sv
// Ordered list of up to DEPTH signed 32-bit values, one entry per cell of a chain.
// Input channel (in_valid_i/in_ready_o) carries mode_i, value_i and position_i.
// Output channel (out_valid_o/out_ready_i) carries status, found index, entry value,
// entry count and a last flag on the final result of each item.
// Insert, search and erase each produce one result, registered in the cycle of
// acceptance; every cell shifts or compares in that same cycle.
// A dump produces count results (one when the list is empty), one per cycle while
// the receiver takes them, by rotating the occupied cells past the head; the next
// item is taken once the final dump result is loaded into the output register.
// Throughput: one item per cycle for insert, search and erase while the receiver
// keeps up; a dump holds off new items until its last entry has rotated out.
// The output register frees itself in the cycle its result is taken, so a new
// item is accepted while a finished result waits only if the receiver takes it.
// When the receiver stalls, the result holds and the input side stalls with it.
// Reset empties the list and the output register; cell contents are not cleared.
module positional_list_engine_unit #(
  parameter int unsigned DEPTH = ple_pkg::DepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic signed [31:0]            value_i,
  input  logic signed [8:0]             position_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [7:0]                    found_index_o,
  output logic signed [31:0]            entry_value_o,
  output logic [8:0]                    entry_count_o,
  output logic                          last_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                       state_q, state_d;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              rem_q, rem_d;
  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 status_q, status_d;
  logic [7:0]                 found_q, found_d;
  logic [31:0]                entry_q, entry_d;
  logic [8:0]                 ecount_q, ecount_d;
  logic                       last_q, last_d;
  logic                       load;

  ple_pkg::cell_ctl_t         ctl;
  logic [ple_pkg::DataW-1:0]  cell_val [DEPTH];
  logic [DEPTH-1:0]           match;
  logic                       hit;
  logic [IW-1:0]              hit_idx;

  logic                       take, acc, neg, beyond;
  logic [8:0]                 count_ext;

  assign take       = out_ready_i || !out_valid_q;
  assign in_ready_o = (state_q == S_IDLE) && take;
  assign acc        = in_valid_i && in_ready_o;
  assign count_ext  = 9'(count_q);
  assign neg        = position_i[8];
  assign beyond     = neg || ({1'b0, position_i[7:0]} >= count_ext);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ple_pkg::DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right = cell_val[i];
    end else begin : g_inner
      assign right = cell_val[i+1];
    end
    ple_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .in_list_i (CW'(i) < count_q),
      .left_i    (left),
      .right_i   (right),
      .head_i    (cell_val[0]),
      .value_o   (cell_val[i]),
      .match_o   (match[i])
    );
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rem_d     = rem_q;
    load      = 1'b0;
    status_d  = ple_pkg::ST_OK;
    found_d   = '0;
    entry_d   = '0;
    ecount_d  = count_ext;
    last_d    = 1'b1;
    ctl.op    = ple_pkg::OP_HOLD;
    ctl.pos   = '0;
    ctl.tail  = ple_pkg::IdxW'(count_q - CW'(1));
    ctl.value = value_i;

    if (state_q == S_DUMP) begin
      if (take) begin
        load     = 1'b1;
        ctl.op   = ple_pkg::OP_ROTATE;
        entry_d  = cell_val[0];
        last_d   = (rem_q == CW'(1));
        rem_d    = rem_q - CW'(1);
        if (rem_q == CW'(1)) begin
          state_d = S_IDLE;
        end
      end
    end else if (acc) begin
      load = 1'b1;
      unique case (ple_pkg::mode_e'(mode_i))
        ple_pkg::MODE_INSERT: begin
          if (count_q == Full) begin
            status_d = ple_pkg::ST_FULL;
          end else begin
            ctl.op   = ple_pkg::OP_INSERT;
            ctl.pos  = beyond ? ple_pkg::IdxW'(count_q) : position_i[7:0];
            count_d  = count_q + CW'(1);
            ecount_d = 9'(count_d);
          end
        end
        ple_pkg::MODE_SEARCH: begin
          if (hit) begin
            found_d = 8'(hit_idx);
          end else begin
            status_d = ple_pkg::ST_MISS;
          end
        end
        ple_pkg::MODE_ERASE: begin
          if (beyond) begin
            status_d = ple_pkg::ST_RANGE;
          end else begin
            ctl.op   = ple_pkg::OP_ERASE;
            ctl.pos  = position_i[7:0];
            count_d  = count_q - CW'(1);
            ecount_d = 9'(count_d);
          end
        end
        ple_pkg::MODE_DUMP: begin
          if (count_q != '0) begin
            ctl.op  = ple_pkg::OP_ROTATE;
            entry_d = cell_val[0];
            last_d  = (count_q == CW'(1));
            rem_d   = count_q - CW'(1);
            if (count_q != CW'(1)) begin
              state_d = S_DUMP;
            end
          end
        end
        default: load = 1'b1;
      endcase
    end
  end

  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      found_q  <= found_d;
      entry_q  <= entry_d;
      ecount_q <= ecount_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign entry_value_o = entry_q;
  assign entry_count_o = ecount_q;
  assign last_o        = last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above depth");

  a_dump_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> !in_ready_o)
    else $error("input taken during dump");

  a_dump_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> rem_q != '0)
    else $error("dump with nothing left");

  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && take && rem_q == CW'(1)) |=> state_q == S_IDLE && last_o)
    else $error("dump did not end on its last entry");

  a_dump_count_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |=> $stable(count_q))
    else $error("count changed during dump");

endmodule
